[hw/rtl/asa_pkg.sv]
// shared types and codes for the affinity slot allocator
package asa_pkg;

  // request codes
  localparam logic [1:0] FUNC_BOOK   = 2'd0;
  localparam logic [1:0] FUNC_SWAP   = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;

  // lowest slot that the free-slot scans consider
  localparam int FIRST_BOOKABLE = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] owner_id;
    logic [3:0]  target_slot;
    logic [15:0] expected_owner;
  } req_t;

  typedef struct packed {
    logic [3:0]  granted_slot;
    logic        success;
    logic [15:0] unprotect_owner;
    logic        unprotect_valid;
  } resp_t;

endpackage

[hw/rtl/affinity_slot_allocator_unit.sv]
// affinity slot allocator: slot table, sequencer and the scan's free-slot compare
// flow: swap, cancel and a hinted book go from idle through hint to done;
// a scanning book walks slots FIRST_BOOKABLE..NUM_SLOTS-1 in up to two passes
// throughput: one beat at a time, in_ready only while idle; the scan reads one
// slot per cycle through the registered read port of the slot table
// reset: all slots read as free and never held (per-slot valid bits cleared)
module affinity_slot_allocator_unit
  import asa_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  req_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output resp_t out_data
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(NUM_SLOTS - 1);
  localparam logic [AW-1:0] FIRST_SLOT = AW'(FIRST_BOOKABLE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HINT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state, state_next;
  req_t       req;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] chk_idx;
  logic       issue, issue_next;
  logic       pend, pend_next;
  logic       pass, pass_next;
  resp_t      res, res_next;

  // slot table storage
  logic [OWNER_BITS-1:0] cur_mem  [NUM_SLOTS];
  logic [OWNER_BITS-1:0] last_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  cur_vld, last_vld;
  logic [OWNER_BITS-1:0] cur_q, last_q;
  logic                  cur_vld_q, last_vld_q;
  logic [OWNER_BITS-1:0] cur_rd, last_rd;

  logic [AW-1:0]         rd_addr;
  logic                  wr_cur, wr_last;
  logic [AW-1:0]         wr_addr;
  logic [OWNER_BITS-1:0] wr_cur_data, wr_last_data;

  // request fields at owner width
  logic [31:0]           owner_ext, expect_ext, tgt_ext, in_tgt_ext;
  logic [OWNER_BITS-1:0] owner_m, expect_m;
  logic [31:0]           owner_m_ext;
  logic                  slot_ok;
  logic                  owner_nz;
  logic                  scan_hit;
  logic [31:0]           victim_ext, grant_ext;
  logic                  out_load;

  assign owner_ext   = 32'(req.owner_id);
  assign expect_ext  = 32'(req.expected_owner);
  assign owner_m     = owner_ext[OWNER_BITS-1:0];
  assign expect_m    = expect_ext[OWNER_BITS-1:0];
  assign owner_m_ext = 32'(owner_m);
  assign tgt_ext     = 32'(req.target_slot);
  assign in_tgt_ext  = 32'(in_data.target_slot);
  assign slot_ok     = (req.target_slot != 4'd0) && (tgt_ext < 32'(NUM_SLOTS));
  assign owner_nz    = (owner_m != '0);

  // entries never written read as zero
  assign cur_rd  = cur_vld_q  ? cur_q  : '0;
  assign last_rd = last_vld_q ? last_q : '0;

  // shared slot test: free, and never held on the first pass
  assign scan_hit = pend && (cur_rd == '0) && (pass || (last_rd == '0));

  assign victim_ext = 32'(last_rd);
  assign grant_ext  = 32'(chk_idx);

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // read address: hint slot on accept, scan index otherwise
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = in_tgt_ext[AW-1:0];
    end else begin
      rd_addr = idx;
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    issue_next   = 1'b0;
    pend_next    = 1'b0;
    pass_next    = pass;
    res_next     = res;
    wr_cur       = 1'b0;
    wr_last      = 1'b0;
    wr_addr      = tgt_ext[AW-1:0];
    wr_cur_data  = owner_m;
    wr_last_data = owner_m;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_HINT;
        end
      end
      ST_HINT: begin
        res_next   = '0;
        state_next = ST_DONE;
        case (req.func)
          FUNC_BOOK: begin
            if (owner_nz) begin
              if (slot_ok && last_rd == owner_m && cur_rd == '0) begin
                wr_cur                = 1'b1;
                res_next.granted_slot = req.target_slot;
                res_next.success      = 1'b1;
              end else begin
                state_next = ST_SCAN;
                idx_next   = FIRST_SLOT;
                issue_next = 1'b1;
                pass_next  = 1'b0;
              end
            end
          end
          FUNC_SWAP: begin
            if (slot_ok && cur_rd == expect_m) begin
              wr_cur           = 1'b1;
              res_next.success = 1'b1;
            end
          end
          FUNC_CANCEL: begin
            if (owner_nz && slot_ok && last_rd == owner_m) begin
              wr_last                  = 1'b1;
              wr_last_data             = '0;
              res_next.success         = 1'b1;
              res_next.unprotect_owner = owner_m_ext[15:0];
              res_next.unprotect_valid = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        // issue the next read while checking the previous slot
        pend_next = issue;
        if (issue && idx != LAST_SLOT) begin
          idx_next   = idx + AW'(1);
          issue_next = 1'b1;
        end
        if (scan_hit) begin
          wr_cur                   = 1'b1;
          wr_last                  = 1'b1;
          wr_addr                  = chk_idx;
          res_next.granted_slot    = grant_ext[3:0];
          res_next.success         = 1'b1;
          res_next.unprotect_owner = victim_ext[15:0];
          res_next.unprotect_valid = (last_rd != '0);
          state_next               = ST_DONE;
        end else if (pend && chk_idx == LAST_SLOT) begin
          if (!pass) begin
            pass_next  = 1'b1;
            idx_next   = FIRST_SLOT;
            issue_next = 1'b1;
            pend_next  = 1'b0;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue     <= 1'b0;
      pend      <= 1'b0;
      pass      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issue     <= issue_next;
      pend      <= pend_next;
      pass      <= pass_next;
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req <= in_data;
    end
    idx     <= idx_next;
    chk_idx <= idx;
    res     <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  // per-slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld  <= '0;
      last_vld <= '0;
    end else begin
      if (wr_cur) begin
        cur_vld[wr_addr] <= 1'b1;
      end
      if (wr_last) begin
        last_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // slot table: one write and one registered read per array
  always_ff @(posedge clk) begin
    if (wr_cur) begin
      cur_mem[wr_addr] <= wr_cur_data;
    end
    if (wr_last) begin
      last_mem[wr_addr] <= wr_last_data;
    end
    cur_q      <= cur_mem[rd_addr];
    last_q     <= last_mem[rd_addr];
    cur_vld_q  <= cur_vld[rd_addr];
    last_vld_q <= last_vld[rd_addr];
  end

  // a failed request carries no slot and no victim
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.success |->
      out_data.granted_slot == 4'd0 && !out_data.unprotect_valid)
    else $error("failed result carries a slot or victim");

  // a victim is only reported for a successful request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.unprotect_valid |-> out_data.success)
    else $error("unprotect without success");

  // the slot table is only written while a request is being worked
  assert property (@(posedge clk) disable iff (rst)
    (wr_cur || wr_last) |-> (state == ST_HINT || state == ST_SCAN))
    else $error("slot table write outside hint or scan");

  // the scan stays within the bookable range
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && pend |-> chk_idx >= FIRST_SLOT && chk_idx <= LAST_SLOT)
    else $error("scan index out of range");

  // a scan hit finishes the request with a grant
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && scan_hit |=> state == ST_DONE && res.success)
    else $error("scan hit did not complete");

endmodule
